>>> rtl/vfc_pkg.sv
package vfc_pkg;

    // Register file
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'd1;

    localparam logic [REG_W-1:0] ALPHA_RST    = 16'd256;   // 1.0 in Q8.8
    localparam logic [REG_W-1:0] MAX_DIST_RST = 16'd2560;  // 10.0 in Q8.8

    // Fractions are Q0.16 with one extra bit so that 1.0 fits
    localparam int FRAC_W = 16;
    localparam int Q_W    = FRAC_W + 1;
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    // Result
    localparam int COST_W = 16;
    localparam logic [COST_W-1:0] COST_SAT = 16'hFFFF;

    // Flags that ride along with an item through the divider stages
    typedef struct packed {
        logic kill;     // cost forced to zero
        logic f2_one;   // both distances zero, edge ratio taken as 1.0
    } side_t;

endpackage

>>> rtl/vfc_div_pipe.sv
module vfc_div_pipe #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [NUM_W-1:0]        num,
    input  logic [DEN_W-1:0]        den,
    output logic [vfc_pkg::Q_W-1:0] quo
);
    import vfc_pkg::*;

    // Restoring divider, one quotient bit per stage, MSB first.
    // Quotient must fit in Q_W bits (num < den * 2**Q_W).
    localparam int SH_W = DEN_W + Q_W - 1;
    localparam int CW   = (NUM_W > SH_W) ? NUM_W : SH_W;

    logic [NUM_W-1:0] rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [CW-1:0]    trial;
        logic             fits;
        logic [Q_W-1:0]   quo_next;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // compare against the divisor aligned to this quotient bit
        assign trial = CW'(den_in) << (Q_W - 1 - j);
        assign fits  = (CW'(rem_in) >= trial);

        always_comb begin
            quo_next = quo_in;
            quo_next[Q_W-1-j] = fits;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[j] <= quo_next;
            end
        end

        if (j < Q_W - 1) begin : g_carry
            logic [NUM_W-1:0] rem_next;

            assign rem_next = fits ? NUM_W'(CW'(rem_in) - trial) : rem_in;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

>>> rtl/voronoi_field_cost.sv
// Voronoi-field path cost, one grid cell per request.
// Throughput: one request per cycle while the output is not stalled; the depth
// comes from three input stages, three 17-stage restoring dividers (one quotient
// bit per stage), two multiply stages and the output register.
// Reset (aresetn low, synchronous): all valid bits clear, alpha = 1.0 and
// max_distance = 10.0; the block is ready as soon as reset is released.
module voronoi_field_cost #(
    parameter int DIST_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [DIST_BITS-1:0] obst_distance, [2*DIST_BITS-1:DIST_BITS] voro_distance
    input  logic [((2*DIST_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // [0] no_edge
    input  logic [0:0]                            s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [15:0] cost
    output logic [vfc_pkg::COST_W-1:0]            m_axis_tdata,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vfc_pkg::REG_W-1:0]             cfg_data
);
    import vfc_pkg::*;

    localparam int DW    = DIST_BITS;
    localparam int OW    = (DW < REG_W) ? DW : REG_W;   // obstacle distance in range
    localparam int CMPW  = (DW > REG_W) ? DW : REG_W;
    localparam int D1W   = REG_W + 1;                   // alpha + do
    localparam int D2W   = DW + 1;                      // do + dv
    localparam int SQ_W  = 2 * REG_W;
    localparam int PRD_W = 2 * Q_W;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [REG_W-1:0] alpha_reg;
    logic [REG_W-1:0] max_dist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= ALPHA_RST;
            max_dist_reg <= MAX_DIST_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ALPHA:    alpha_reg    <= cfg_data;
                REG_MAX_DIST: max_dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: stall only when the skid slot is full and the
    // last stage holds an item.
    logic en;
    logic skid_full_reg;
    logic v_m2_reg;

    assign en            = ~skid_full_reg | ~v_m2_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: input capture
    logic          v_s1_reg;
    logic [DW-1:0] s1_obst_reg;
    logic [DW-1:0] s1_voro_reg;
    logic          s1_noedge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s1_reg <= 1'b0;
        end else if (en) begin
            v_s1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_obst_reg   <= s_axis_tdata[DW-1:0];
            s1_voro_reg   <= s_axis_tdata[2*DW-1:DW];
            s1_noedge_reg <= s_axis_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: zero-cost decision, divisor sums, distance to dmax
    logic [OW-1:0]    do_eff;
    side_t            s2_side_next;
    logic [D1W-1:0]   f1_den_next;
    logic [D2W-1:0]   f2_den_next;
    logic [REG_W-1:0] diff_next;

    assign do_eff      = s1_obst_reg[OW-1:0];
    assign f1_den_next = D1W'(alpha_reg) + D1W'(do_eff);
    assign f2_den_next = D2W'(do_eff) + D2W'(s1_voro_reg);
    assign diff_next   = max_dist_reg - REG_W'(do_eff);

    always_comb begin
        s2_side_next.kill   = s1_noedge_reg
                            | (CMPW'(s1_obst_reg) >= CMPW'(max_dist_reg))
                            | (alpha_reg == '0);
        s2_side_next.f2_one = (f2_den_next == '0);
    end

    logic             v_s2_reg;
    side_t            s2_side_reg;
    logic [D1W-1:0]   s2_f1_den_reg;
    logic [DW-1:0]    s2_voro_reg;
    logic [D2W-1:0]   s2_f2_den_reg;
    logic [REG_W-1:0] s2_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s2_reg <= 1'b0;
        end else if (en) begin
            v_s2_reg <= v_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg   <= s2_side_next;
            s2_f1_den_reg <= f1_den_next;
            s2_voro_reg   <= s1_voro_reg;
            s2_f2_den_reg <= f2_den_next;
            s2_diff_reg   <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares for the falloff term
    logic            v_s3_reg;
    side_t           s3_side_reg;
    logic [D1W-1:0]  s3_f1_den_reg;
    logic [DW-1:0]   s3_voro_reg;
    logic [D2W-1:0]  s3_f2_den_reg;
    logic [SQ_W-1:0] s3_sq_reg;
    logic [SQ_W-1:0] s3_msq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_s3_reg <= 1'b0;
        end else if (en) begin
            v_s3_reg <= v_s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg   <= s2_side_reg;
            s3_f1_den_reg <= s2_f1_den_reg;
            s3_voro_reg   <= s2_voro_reg;
            s3_f2_den_reg <= s2_f2_den_reg;
            s3_sq_reg     <= SQ_W'(s2_diff_reg) * SQ_W'(s2_diff_reg);
            s3_msq_reg    <= SQ_W'(max_dist_reg) * SQ_W'(max_dist_reg);
        end
    end

    // ------------------------------------------------------------------
    // Dividers: f1 = alpha/(alpha+do), f2 = dv/(do+dv),
    // f3 = (dmax-do)^2/dmax^2, all Q0.16
    logic [Q_W-1:0] f1_quo;
    logic [Q_W-1:0] f2_quo;
    logic [Q_W-1:0] f3_quo;

    vfc_div_pipe #(
        .NUM_W (REG_W + FRAC_W),
        .DEN_W (D1W)
    ) u_div_f1 (
        .aclk (aclk),
        .en   (en),
        .num  ({alpha_reg, {FRAC_W{1'b0}}}),
        .den  (s3_f1_den_reg),
        .quo  (f1_quo)
    );

    vfc_div_pipe #(
        .NUM_W (DW + FRAC_W),
        .DEN_W (D2W)
    ) u_div_f2 (
        .aclk (aclk),
        .en   (en),
        .num  ({s3_voro_reg, {FRAC_W{1'b0}}}),
        .den  (s3_f2_den_reg),
        .quo  (f2_quo)
    );

    vfc_div_pipe #(
        .NUM_W (SQ_W + FRAC_W),
        .DEN_W (SQ_W)
    ) u_div_f3 (
        .aclk (aclk),
        .en   (en),
        .num  ({s3_sq_reg, {FRAC_W{1'b0}}}),
        .den  (s3_msq_reg),
        .quo  (f3_quo)
    );

    // valid bits and flags matching the divider stages
    logic  v_div_reg    [Q_W];
    side_t side_div_reg [Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Q_W; i++) begin
                v_div_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_div_reg[0] <= v_s3_reg;
            for (int i = 1; i < Q_W; i++) begin
                v_div_reg[i] <= v_div_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_div_reg[0] <= s3_side_reg;
            for (int i = 1; i < Q_W; i++) begin
                side_div_reg[i] <= side_div_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // M1: p = f1 * f2 >> 16, zero when the cell carries no cost
    side_t            div_side;
    logic [Q_W-1:0]   f2_val;
    logic [PRD_W-1:0] prod1;
    logic [Q_W-1:0]   p_next;

    assign div_side = side_div_reg[Q_W-1];
    assign f2_val   = div_side.f2_one ? Q_ONE : f2_quo;
    assign prod1    = PRD_W'(f1_quo) * PRD_W'(f2_val);
    assign p_next   = div_side.kill ? '0 : prod1[Q_W+FRAC_W-1:FRAC_W];

    logic           v_m1_reg;
    logic           m1_kill_reg;
    logic [Q_W-1:0] m1_p_reg;
    logic [Q_W-1:0] m1_f3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_m1_reg <= 1'b0;
        end else if (en) begin
            v_m1_reg <= v_div_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_kill_reg <= div_side.kill;
            m1_p_reg    <= p_next;
            m1_f3_reg   <= f3_quo;
        end
    end

    // ------------------------------------------------------------------
    // M2: cost = p * f3 >> 16, saturated to full cost
    logic [PRD_W-1:0]  prod2;
    logic [Q_W-1:0]    c_full;
    logic [COST_W-1:0] cost_next;

    assign prod2     = PRD_W'(m1_p_reg) * PRD_W'(m1_f3_reg);
    assign c_full    = prod2[Q_W+FRAC_W-1:FRAC_W];
    assign cost_next = c_full[Q_W-1] ? COST_SAT : c_full[COST_W-1:0];

    logic              m2_kill_reg;
    logic [COST_W-1:0] m2_cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_m2_reg <= 1'b0;
        end else if (en) begin
            v_m2_reg <= v_m1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_kill_reg <= m1_kill_reg;
            m2_cost_reg <= cost_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid slot
    logic              m_valid_reg;
    logic [COST_W-1:0] m_cost_reg;
    logic [COST_W-1:0] skid_cost_reg;
    logic              out_free;
    logic              take_last;

    assign out_free  = ~m_valid_reg | m_axis_tready;
    assign take_last = en & v_m2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_full_reg) begin
                m_valid_reg   <= 1'b1;
                skid_full_reg <= 1'b0;
            end else begin
                m_valid_reg   <= take_last;
            end
        end else if (take_last) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_cost_reg <= skid_full_reg ? skid_cost_reg : m2_cost_reg;
        end else if (take_last) begin
            skid_cost_reg <= m2_cost_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_cost_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid slot full while output register empty");

    a_stall_holds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v_m2_reg) && $stable(m2_cost_reg)))
        else $error("last stage changed during stall");

    a_kill_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_m2_reg && m2_kill_reg) |-> (m2_cost_reg == '0))
        else $error("zero-cost cell produced nonzero cost");

endmodule
